// ===== hw/rtl/srfl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srfl_pkg
// Shared types, sizes and helpers for the segmented register free list.
// ----------------------------------------------------------------------------
package srfl_pkg;

    localparam int NUM_SEGMENTS  = 4;
    localparam int SEG_DEPTH     = 64;
    localparam int STORE_DEPTH   = NUM_SEGMENTS * SEG_DEPTH;

    localparam int SEG_FIELD_W   = 2;
    localparam int REG_NUM_W     = 8;
    localparam int CAP_W         = 7;
    localparam int OUT_CNT_W     = 7;
    localparam int STATUS_W      = 2;
    localparam int CAP_REG_COUNT = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = CAP_W;
    localparam int CAP_RESET     = 64;

    localparam int SEG_IDX_W     = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int HEAD_W        = $clog2(SEG_DEPTH);
    localparam int CNT_W         = $clog2(SEG_DEPTH + 1);
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_QUERY   = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic [CNT_W-1:0] cnt_t;

    // capacity values above the segment depth saturate at the depth
    function automatic cnt_t cap_clamp(input logic [CAP_W-1:0] cap);
        cnt_t res;
        if (32'(cap) > SEG_DEPTH) begin
            res = CNT_W'(SEG_DEPTH);
        end else begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/segmented_register_free_list_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_register_free_list_core
// Per-segment FIFO free lists of physical register numbers for renaming.
// ----------------------------------------------------------------------------
// One request per cycle is taken and each gives exactly one result in the
// next cycle from the output register; a waiting result does not block the next
// request as long as the result side takes it in the same cycle. Allocate
// pops the oldest number of a segment, release appends at the tail, and any
// other code reports the free count. Writing a capacity register rebuilds all
// lists at once: every store entry has a fill bit, and an entry not yet
// written reads as its start-up number, so there is no clearing sweep and the
// block is ready right after reset or a capacity write.
module segmented_register_free_list_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: reg_number[7:0]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,
    // s_tuser: req_type[1:0], segment[3:2]
    input  wire logic [3:0]                      s_tuser,
    // m_tdata: alloc_reg[7:0], free_count[14:8], zero[15]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [15:0]                     m_tdata,
    // m_tuser: status[1:0]
    output logic      [1:0]                      m_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [srfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [srfl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import srfl_pkg::*;

    logic [CAP_W-1:0]     cap_reg  [NUM_SEGMENTS];
    logic [CAP_W-1:0]     cap_next [NUM_SEGMENTS];
    logic [HEAD_W-1:0]    head_reg [NUM_SEGMENTS];
    cnt_t                 cnt_reg  [NUM_SEGMENTS];
    logic [REG_NUM_W-1:0] base_num [NUM_SEGMENTS];
    logic [STORE_DEPTH-1:0] filled_reg;

    logic                 m_valid_reg;
    logic                 alloc_ok_reg;
    logic                 hit_reg;
    logic [REG_NUM_W-1:0] init_reg;
    logic [OUT_CNT_W-1:0] cnt_out_reg;
    status_t              status_reg;

    logic                 accept;
    req_t                 req;
    logic [SEG_FIELD_W-1:0] seg;
    logic [SEG_IDX_W-1:0] seg_idx;
    logic                 seg_ok;
    logic [HEAD_W-1:0]    cur_head;
    cnt_t                 cur_cnt;
    logic                 alloc_ok;
    logic                 rel_ok;
    logic [CNT_W:0]       tail_sum;
    logic [HEAD_W-1:0]    tail;
    logic [HEAD_W-1:0]    head_inc;
    logic [ADDR_W-1:0]    seg_base;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    cnt_t                 cnt_after;
    status_t              status_now;
    logic                 cfg_hit;
    logic [REG_NUM_W-1:0] ram_q;
    logic [REG_NUM_W-1:0] alloc_val;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;

    assign req      = req_t'(s_tuser[1:0]);
    assign seg      = s_tuser[3:2];
    assign seg_ok   = 4'(seg) < 4'(NUM_SEGMENTS);
    assign seg_idx  = SEG_IDX_W'(seg);
    assign cur_head = seg_ok ? head_reg[seg_idx] : '0;
    assign cur_cnt  = seg_ok ? cnt_reg[seg_idx] : '0;

    assign alloc_ok = seg_ok && (req == REQ_ALLOC) && (cur_cnt != '0);
    assign rel_ok   = seg_ok && (req == REQ_RELEASE) && (cur_cnt != CNT_W'(SEG_DEPTH));

    // tail slot of the ring, head plus count wrapped once
    assign tail_sum = (CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_cnt);
    assign tail     = (tail_sum >= (CNT_W+1)'(SEG_DEPTH))
                    ? HEAD_W'(tail_sum - (CNT_W+1)'(SEG_DEPTH)) : HEAD_W'(tail_sum);
    assign head_inc = (32'(cur_head) == SEG_DEPTH - 1) ? '0 : cur_head + 1'b1;

    assign seg_base = ADDR_W'(seg_idx) * ADDR_W'(SEG_DEPTH);
    assign rd_addr  = seg_base + ADDR_W'(cur_head);
    assign wr_addr  = seg_base + ADDR_W'(tail);

    always_comb begin
        cnt_after = cur_cnt;
        if (alloc_ok) begin
            cnt_after = cur_cnt - 1'b1;
        end else if (rel_ok) begin
            cnt_after = cur_cnt + 1'b1;
        end
    end

    always_comb begin
        status_now = ST_OK;
        if (req == REQ_ALLOC && !alloc_ok) begin
            status_now = ST_EMPTY;
        end else if (req == REQ_RELEASE && !rel_ok) begin
            status_now = ST_FULL;
        end
    end

    // start-up numbers: each segment begins after the lower capacities
    always_comb begin
        base_num[0] = '0;
        for (int s = 1; s < NUM_SEGMENTS; s++) begin
            base_num[s] = base_num[s-1] + REG_NUM_W'(cap_reg[s-1]);
        end
    end

    assign cfg_hit = cfg_we && (4'(cfg_index) < 4'(NUM_SEGMENTS))
                            && (4'(cfg_index) < 4'(CAP_REG_COUNT));

    always_comb begin
        for (int s = 0; s < NUM_SEGMENTS; s++) begin
            cap_next[s] = cap_reg[s];
        end
        if (cfg_hit) begin
            cap_next[SEG_IDX_W'(cfg_index)] = CAP_W'(cap_clamp(cfg_wdata));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_SEGMENTS; s++) begin
                cap_reg[s]  <= CAP_W'(cap_clamp(CAP_W'(CAP_RESET)));
                head_reg[s] <= '0;
                cnt_reg[s]  <= cap_clamp(CAP_W'(CAP_RESET));
            end
            filled_reg <= '0;
        end else if (cfg_hit) begin
            for (int s = 0; s < NUM_SEGMENTS; s++) begin
                cap_reg[s]  <= cap_next[s];
                head_reg[s] <= '0;
                cnt_reg[s]  <= CNT_W'(cap_next[s]);
            end
            filled_reg <= '0;
        end else if (accept && seg_ok) begin
            cnt_reg[seg_idx] <= cnt_after;
            if (alloc_ok) begin
                head_reg[seg_idx] <= head_inc;
            end
            if (rel_ok) begin
                filled_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            alloc_ok_reg <= alloc_ok;
            hit_reg      <= filled_reg[rd_addr];
            init_reg     <= base_num[seg_idx] + REG_NUM_W'(cur_head);
            cnt_out_reg  <= OUT_CNT_W'(cnt_after);
            status_reg   <= status_now;
        end
    end

    srfl_ram #(
        .WIDTH (REG_NUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (accept && rel_ok && !cfg_hit),
        .waddr (wr_addr),
        .wdata (s_tdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign alloc_val = !alloc_ok_reg ? '0 : (hit_reg ? ram_q : init_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, cnt_out_reg, alloc_val};
    assign m_tuser  = status_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/srfl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== tb/srfl_free_list_checker.sv =====
// ----------------------------------------------------------------------------
// srfl_free_list_checker
// Watches the request, result and capacity-write ports of the segmented free
// list, keeps its own copy of every segment ring, and compares each result
// transaction field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module srfl_free_list_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic [3:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,
    input  logic [1:0]                      m_tuser,
    input  logic                            cfg_we,
    input  logic [srfl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srfl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending_results,
    output int                              requests_seen,
    output int                              empty_allocs,
    output int                              full_releases
);
    timeunit 1ns;
    timeprecision 1ps;
    import srfl_pkg::*;

    typedef struct packed {
        logic [REG_NUM_W-1:0] alloc_reg;
        logic [OUT_CNT_W-1:0] free_count;
        status_t              status;
    } free_result_t;

    logic [CAP_W-1:0]     capacity   [NUM_SEGMENTS];
    logic [REG_NUM_W-1:0] ring_store [STORE_DEPTH];
    int                   head_idx   [NUM_SEGMENTS];
    int                   fill_level [NUM_SEGMENTS];

    free_result_t expected_q [$];
    free_result_t want;
    free_result_t got;
    int           mismatch_count = 0;
    int           n_requests = 0;
    int           n_empty = 0;
    int           n_full = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 30) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // every segment restarts with consecutive numbers after the lower segments
    function automatic void rebuild_free_lists();
        logic [REG_NUM_W-1:0] next_num;
        int                   lim;
        next_num = '0;
        foreach (ring_store[i]) ring_store[i] = '0;
        for (int s = 0; s < NUM_SEGMENTS; s++) begin
            lim = (int'(capacity[s]) > SEG_DEPTH) ? SEG_DEPTH : int'(capacity[s]);
            for (int i = 0; i < lim; i++) begin
                ring_store[s * SEG_DEPTH + i] = next_num;
                next_num++;
            end
            head_idx[s]   = 0;
            fill_level[s] = lim;
        end
    endfunction

    function automatic free_result_t predict_request(input logic [1:0] code,
                                                     input logic [SEG_FIELD_W-1:0] seg,
                                                     input logic [REG_NUM_W-1:0] num);
        free_result_t res;
        int           base;
        int           tail;
        res.alloc_reg  = '0;
        res.free_count = '0;
        res.status     = ST_OK;
        base = int'(seg) * SEG_DEPTH;
        if (code == REQ_ALLOC) begin
            if (fill_level[seg] == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.alloc_reg = ring_store[base + head_idx[seg]];
                head_idx[seg] = (head_idx[seg] + 1) % SEG_DEPTH;
                fill_level[seg]--;
            end
        end else if (code == REQ_RELEASE) begin
            if (fill_level[seg] >= SEG_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                tail = (head_idx[seg] + fill_level[seg]) % SEG_DEPTH;
                ring_store[base + tail] = num;
                fill_level[seg]++;
            end
        end
        res.free_count = OUT_CNT_W'(fill_level[seg]);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (capacity[s]) capacity[s] = CAP_W'(CAP_RESET);
            rebuild_free_lists();
            expected_q.delete();
        end else begin
            if (cfg_we && cfg_index < CAP_REG_COUNT && cfg_index < NUM_SEGMENTS) begin
                capacity[cfg_index] = cfg_wdata;
                rebuild_free_lists();
            end
            // results come from requests taken earlier, so match them first
            if (m_tvalid && m_tready) begin
                got.alloc_reg  = m_tdata[7:0];
                got.free_count = m_tdata[14:8];
                got.status     = status_t'(m_tuser);
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result transaction with nothing expected: %h %h",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (got.alloc_reg !== want.alloc_reg) begin
                        report_mismatch($sformatf("alloc_reg %0d, expected %0d",
                                                  got.alloc_reg, want.alloc_reg));
                    end
                    if (got.free_count !== want.free_count) begin
                        report_mismatch($sformatf("free_count %0d, expected %0d",
                                                  got.free_count, want.free_count));
                    end
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, want.status));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = predict_request(s_tuser[1:0], s_tuser[3:2], s_tdata);
                if (want.status == ST_EMPTY) n_empty++;
                if (want.status == ST_FULL) n_full++;
                n_requests++;
                expected_q = {expected_q, want};
            end
        end
        fail_count      <= mismatch_count;
        pending_results <= expected_q.size();
        requests_seen   <= n_requests;
        empty_allocs    <= n_empty;
        full_releases   <= n_full;
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the segmented register free list: directed corner requests,
// then bursts of allocates, releases and queries aimed mostly at one segment at a time under
// several capacity settings, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import srfl_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 60;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_TICKS = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic [3:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   fail_count;
    int   pending_results;
    int   requests_seen;
    int   empty_allocs;
    int   full_releases;

    logic steady = 1'b0;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   cap_settings = 1;

    segmented_register_free_list_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    srfl_free_list_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .requests_seen   (requests_seen),
        .empty_allocs    (empty_allocs),
        .full_releases   (full_releases)
    );

    initial begin
        forever begin
            #6 aclk = ~aclk;
        end
    end

    // result side: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            stall_left   <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 19);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [1:0] code, input logic [1:0] seg,
                                input logic [7:0] num);
        while (!steady && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {seg, code};
        s_tdata  <= num;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
    endtask

    task automatic write_capacities(input logic [CAP_W-1:0] c0, input logic [CAP_W-1:0] c1,
                                    input logic [CAP_W-1:0] c2, input logic [CAP_W-1:0] c3);
        logic [CAP_W-1:0] caps [CAP_REG_COUNT];
        caps = '{c0, c1, c2, c3};
        drain_results();
        for (int r = 0; r < CAP_REG_COUNT; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_wdata <= caps[r];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        cap_settings++;
    endtask

    // bursts mostly on one segment, leaning toward allocate or release so that
    // small lists run empty and refill
    task automatic burst_traffic(input int n_items);
        int         done;
        int         burst_len;
        int         alloc_pct;
        int         roll;
        logic [1:0] hot_seg;
        done = 0;
        while (done < n_items) begin
            hot_seg   = 2'($urandom_range(NUM_SEGMENTS - 1));
            burst_len = $urandom_range(4, 40);
            alloc_pct = $urandom_range(1) ? 85 : 15;
            for (int i = 0; i < burst_len && done < n_items; i++) begin
                roll = $urandom_range(99);
                if (roll < 4) begin
                    send_request(REQ_UNUSED, 2'($urandom), 8'($urandom));
                end else if (roll < 12) begin
                    send_request(REQ_QUERY, hot_seg, 8'($urandom));
                end else if (roll < 20) begin
                    send_request($urandom_range(1) ? REQ_ALLOC : REQ_RELEASE,
                                 2'($urandom), 8'($urandom));
                end else if ($urandom_range(99) < alloc_pct) begin
                    send_request(REQ_ALLOC, hot_seg, 8'($urandom));
                end else begin
                    send_request(REQ_RELEASE, hot_seg, 8'($urandom));
                end
                done++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset lists are all full
        for (int s = 0; s < NUM_SEGMENTS; s++) begin
            send_request(REQ_QUERY, 2'(s), 8'h00);
        end
        send_request(REQ_UNUSED, 2'd2, 8'hFF);
        send_request(REQ_RELEASE, 2'd1, 8'hFF);
        send_request(REQ_ALLOC, 2'd0, 8'h00);
        send_request(REQ_ALLOC, 2'd3, 8'hFF);
        send_request(REQ_RELEASE, 2'd0, 8'h00);
        send_request(REQ_RELEASE, 2'd0, 8'hFF);
        burst_traffic(250);

        // empty segment, single entry, full depth and oversized capacity
        write_capacities(7'd0, 7'd1, 7'd64, 7'd127);
        send_request(REQ_ALLOC, 2'd0, 8'h00);
        send_request(REQ_RELEASE, 2'd0, 8'hAA);
        send_request(REQ_ALLOC, 2'd0, 8'h55);
        send_request(REQ_ALLOC, 2'd1, 8'h00);
        send_request(REQ_ALLOC, 2'd1, 8'h00);
        send_request(REQ_QUERY, 2'd3, 8'h00);
        send_request(REQ_ALLOC, 2'd2, 8'h00);
        send_request(REQ_ALLOC, 2'd3, 8'h00);
        burst_traffic(250);

        write_capacities(7'd3, 7'd5, 7'd2, 7'd8);
        steady <= 1'b1;
        burst_traffic(150);
        steady <= 1'b0;
        hold_requests <= hold_requests + 1;
        burst_traffic(150);
        drain_results();
        burst_traffic(50);

        write_capacities(7'($urandom_range(127)), 7'($urandom_range(127)),
                         7'($urandom_range(127)), 7'($urandom_range(127)));
        burst_traffic(300);

        write_capacities(7'd10, 7'd0, 7'd33, 7'd64);
        hold_requests <= hold_requests + 1;
        burst_traffic(300);

        drain_results();
        repeat (SETTLE_TICKS) @(posedge aclk);
        $display("covered %0d requests under %0d capacity settings", requests_seen,
                 cap_settings);
        $display("%0d allocates from empty lists, %0d releases into full lists",
                 empty_allocs, full_releases);
        if (fail_count == 0 && pending_results == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
